// ===== rtl/core/ghv_pkg.sv =====
// ghv_pkg: shared widths, register codes and control types of the circle hough voter
package ghv_pkg;

  // default sizes handed to the top level parameters
  localparam int IMAGE_WIDTH_DEF     = 128;
  localparam int IMAGE_HEIGHT_DEF    = 128;
  localparam int MAX_RADIUS_BINS_DEF = 16;
  localparam int COUNT_WIDTH_DEF     = 16;

  // fixed field widths
  localparam int PIX_W      = 7;
  localparam int DIR_W      = 16;
  localparam int RAD_W      = 12;
  localparam int STEP_W     = 8;
  localparam int BINS_CFG_W = 5;
  localparam int VOTES_W    = 16;
  localparam int BRAD_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // running radius needs one bit more than the register so that it can pass the end
  localparam int R_W = RAD_W + 1;

  // fixed point
  localparam int FRAC_SHIFT   = 18;
  localparam int SKIP_MAG     = 640;
  localparam int ROUND_ADD    = 8;
  localparam int PIX_SUBBITS  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_START = 2'd0,
    CFG_RADIUS_END   = 2'd1,
    CFG_RADIUS_STEP  = 2'd2,
    CFG_RADIUS_BINS  = 2'd3
  } cfg_reg_e;

  localparam logic [RAD_W-1:0]      RADIUS_START_RST = 12'd0;
  localparam logic [RAD_W-1:0]      RADIUS_END_RST   = 12'd1024;
  localparam logic [STEP_W-1:0]     RADIUS_STEP_RST  = 8'd16;
  localparam logic [BINS_CFG_W-1:0] RADIUS_BINS_RST  = 5'd16;

  typedef struct packed {
    logic clear;
    logic start;
    logic advance;
    logic div_load;
    logic div_step;
    logic calc;
    logic read;
    logic write;
    logic finish;
  } ghv_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic r_done;
    logic r_skip;
    logic div_last;
    logic centre_ok;
    logic out_busy;
  } ghv_stat_t;

endpackage

// ===== rtl/core/ghv_if.sv =====
// ghv_if: edge pixel and best vote channel interfaces
interface ghv_in_if;
  logic                             valid;
  logic                             ready;
  logic [ghv_pkg::PIX_W-1:0]        pixel_x;
  logic [ghv_pkg::PIX_W-1:0]        pixel_y;
  logic signed [ghv_pkg::DIR_W-1:0] cos_dir;
  logic signed [ghv_pkg::DIR_W-1:0] sin_dir;

  modport source (output valid, output pixel_x, output pixel_y, output cos_dir,
                  output sin_dir, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input cos_dir,
                  input sin_dir, output ready);
endinterface

interface ghv_out_if;
  logic                        valid;
  logic                        ready;
  logic [ghv_pkg::VOTES_W-1:0] best_votes;
  logic [ghv_pkg::PIX_W-1:0]   best_x;
  logic [ghv_pkg::PIX_W-1:0]   best_y;
  logic [ghv_pkg::BRAD_W-1:0]  best_radius;

  modport source (output valid, output best_votes, output best_x, output best_y,
                  output best_radius, input ready);
  modport sink   (input valid, input best_votes, input best_x, input best_y,
                  input best_radius, output ready);
endinterface

// ===== rtl/core/ghv_ram.sv =====
// ghv_ram: generic single write port ram with registered read
module ghv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/ghv_ctrl.sv =====
// ghv_ctrl: sequencer of the clearing pass and of the radius steps of one pixel
module ghv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ghv_pkg::ghv_stat_t  stat_i,
  output ghv_pkg::ghv_cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_STEP   = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_CALC   = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_STEP;
        end
      end
      S_STEP: begin
        priority if (stat_i.r_done) begin
          state_d = S_FINISH;
        end else if (stat_i.r_skip) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (stat_i.centre_ok) begin
          state_d = S_READ;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_STEP;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write   = 1'b1;
        cmd_o.advance = 1'b1;
        state_d       = S_STEP;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ghv_dpath.sv =====
// ghv_dpath: config registers, radius walk, bin divider, centre arithmetic and vote store
module ghv_dpath #(
  parameter int IMAGE_WIDTH     = ghv_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT    = ghv_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_RADIUS_BINS = ghv_pkg::MAX_RADIUS_BINS_DEF,
  parameter int COUNT_WIDTH     = ghv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ghv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ghv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  ghv_pkg::ghv_cmd_t                 cmd_i,
  output ghv_pkg::ghv_stat_t                stat_o,
  input  logic [ghv_pkg::PIX_W-1:0]         pixel_x_i,
  input  logic [ghv_pkg::PIX_W-1:0]         pixel_y_i,
  input  logic signed [ghv_pkg::DIR_W-1:0]  cos_dir_i,
  input  logic signed [ghv_pkg::DIR_W-1:0]  sin_dir_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ghv_pkg::VOTES_W-1:0]       best_votes_o,
  output logic [ghv_pkg::PIX_W-1:0]         best_x_o,
  output logic [ghv_pkg::PIX_W-1:0]         best_y_o,
  output logic [ghv_pkg::BRAD_W-1:0]        best_radius_o
);

  localparam int R_W    = ghv_pkg::R_W;
  localparam int BINS_W = $clog2(MAX_RADIUS_BINS + 1);
  localparam int QW     = (MAX_RADIUS_BINS > 1) ? $clog2(MAX_RADIUS_BINS) : 1;
  localparam int IDX_W  = (QW > 1) ? $clog2(QW) : 1;
  localparam int NUM_W  = R_W + BINS_W;
  localparam int SB_W   = ghv_pkg::STEP_W + BINS_W;
  localparam int XW     = $clog2(IMAGE_WIDTH);
  localparam int YW     = $clog2(IMAGE_HEIGHT);
  localparam int DEPTH  = MAX_RADIUS_BINS * IMAGE_HEIGHT * IMAGE_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = R_W + ghv_pkg::DIR_W;
  localparam int VW     = 32;
  localparam int FRAC   = ghv_pkg::FRAC_SHIFT;

  localparam logic signed [VW-1:0] V_HALF = VW'(2 ** (FRAC - 1));
  localparam logic signed [VW-1:0] V_LO   = VW'(-(2 ** FRAC));
  localparam logic signed [VW-1:0] V_HI_X = VW'(IMAGE_WIDTH * (2 ** FRAC));
  localparam logic signed [VW-1:0] V_HI_Y = VW'(IMAGE_HEIGHT * (2 ** FRAC));

  // configuration
  logic signed [ghv_pkg::RAD_W-1:0] rs_q, re_q;
  logic [ghv_pkg::STEP_W-1:0]       step_q;
  logic [ghv_pkg::BINS_CFG_W-1:0]   bins_q;

  logic [ghv_pkg::STEP_W-1:0] step_eff;
  logic [BINS_W-1:0]          bins_eff;
  logic signed [R_W-1:0]      span;
  logic [SB_W-1:0]            step_bins;

  // item and walk registers
  logic [ghv_pkg::PIX_W-1:0]        px_q, py_q;
  logic signed [ghv_pkg::DIR_W-1:0] cos_q, sin_q;
  logic signed [R_W-1:0]            r_q;
  logic [NUM_W-1:0]                 num_q;
  logic [ghv_pkg::RAD_W-1:0]        span_q;
  logic [SB_W-1:0]                  step_bins_q;
  logic [R_W-1:0]                   mag, mag_rnd;

  // divider
  logic [NUM_W-1:0] rem_q, trial;
  logic [QW-1:0]    quo_q;
  logic [IDX_W-1:0] idx_q;

  // centre
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [VW-1:0] px_s, py_s, vx, vy;
  logic [XW-1:0]        x0, x0_q;
  logic [YW-1:0]        y0, y0_q;
  logic [BINS_W-1:0]    bins_m1;
  logic [QW-1:0]        bin;
  logic [AW-1:0]        addr, addr_q;
  logic [ghv_pkg::BRAD_W-1:0] rad_q;

  // votes
  logic [AW-1:0]          clr_addr_q;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_new;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  logic [COUNT_WIDTH-1:0]     max_votes_q;
  logic [XW-1:0]              max_x_q;
  logic [YW-1:0]              max_y_q;
  logic [ghv_pkg::BRAD_W-1:0] max_rad_q;
  logic                       out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= ghv_pkg::RADIUS_START_RST;
      re_q   <= ghv_pkg::RADIUS_END_RST;
      step_q <= ghv_pkg::RADIUS_STEP_RST;
      bins_q <= ghv_pkg::RADIUS_BINS_RST;
    end else if (cfg_we_i) begin
      unique case (ghv_pkg::cfg_reg_e'(cfg_idx_i))
        ghv_pkg::CFG_RADIUS_START: rs_q   <= cfg_data_i;
        ghv_pkg::CFG_RADIUS_END:   re_q   <= cfg_data_i;
        ghv_pkg::CFG_RADIUS_STEP:  step_q <= cfg_data_i[ghv_pkg::STEP_W-1:0];
        ghv_pkg::CFG_RADIUS_BINS:  bins_q <= cfg_data_i[ghv_pkg::BINS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero step acts as one, bins clamped to one..max
  always_comb begin
    step_eff = (step_q == '0) ? ghv_pkg::STEP_W'(1) : step_q;
    if (bins_q == '0) begin
      bins_eff = BINS_W'(1);
    end else if (32'(bins_q) > MAX_RADIUS_BINS) begin
      bins_eff = BINS_W'(MAX_RADIUS_BINS);
    end else begin
      bins_eff = BINS_W'(bins_q);
    end
  end

  assign span      = R_W'(re_q) - R_W'(rs_q);
  assign step_bins = SB_W'(step_eff) * SB_W'(bins_eff);

  assign mag     = r_q[R_W-1] ? R_W'(-r_q) : R_W'(r_q);
  assign mag_rnd = mag + R_W'(ghv_pkg::ROUND_ADD);

  // radius walk; num tracks (r - start) * bins
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q        <= pixel_x_i;
      py_q        <= pixel_y_i;
      cos_q       <= cos_dir_i;
      sin_q       <= sin_dir_i;
      r_q         <= R_W'(rs_q);
      num_q       <= '0;
      span_q      <= span[ghv_pkg::RAD_W-1:0];
      step_bins_q <= step_bins;
    end else if (cmd_i.advance) begin
      r_q   <= r_q + R_W'(step_eff);
      num_q <= num_q + NUM_W'(step_bins_q);
    end
  end

  // restoring divider, one quotient bit a cycle
  assign trial = NUM_W'(span_q) << idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q    <= num_q;
      quo_q    <= '0;
      idx_q    <= IDX_W'(QW - 1);
      prod_x_q <= PW'(r_q) * PW'(cos_q);
      prod_y_q <= PW'(r_q) * PW'(sin_q);
    end else if (cmd_i.div_step) begin
      if (rem_q >= trial) begin
        rem_q        <= rem_q - trial;
        quo_q[idx_q] <= 1'b1;
      end
      idx_q <= idx_q - IDX_W'(1);
    end
  end

  // centre = pixel - r*dir + half, truncated toward zero
  assign px_s = VW'(px_q) << FRAC;
  assign py_s = VW'(py_q) << FRAC;
  assign vx   = px_s - VW'(prod_x_q) + V_HALF;
  assign vy   = py_s - VW'(prod_y_q) + V_HALF;
  assign x0   = vx[VW-1] ? '0 : vx[FRAC +: XW];
  assign y0   = vy[VW-1] ? '0 : vy[FRAC +: YW];

  assign bins_m1 = bins_eff - BINS_W'(1);
  assign bin     = (BINS_W'(quo_q) > bins_m1) ? QW'(bins_m1) : quo_q;
  assign addr    = (AW'(bin) * AW'(IMAGE_HEIGHT) + AW'(y0)) * AW'(IMAGE_WIDTH) + AW'(x0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q <= addr;
      x0_q   <= x0;
      y0_q   <= y0;
      rad_q  <= mag_rnd[ghv_pkg::PIX_SUBBITS +: ghv_pkg::BRAD_W];
    end
  end

  // vote store
  assign cnt_new   = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);
  assign ram_we    = cmd_i.clear | cmd_i.write;
  assign ram_waddr = cmd_i.clear ? clr_addr_q : addr_q;
  assign ram_wdata = cmd_i.clear ? '0 : cnt_new;

  ghv_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ghv_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (addr_q),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // tracked maximum, strictly greater replaces
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_votes_q <= '0;
      max_x_q     <= '0;
      max_y_q     <= '0;
      max_rad_q   <= '0;
    end else if (cmd_i.write && (cnt_new > max_votes_q)) begin
      max_votes_q <= cnt_new;
      max_x_q     <= x0_q;
      max_y_q     <= y0_q;
      max_rad_q   <= rad_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      best_votes_o  <= ghv_pkg::VOTES_W'(max_votes_q);
      best_x_o      <= ghv_pkg::PIX_W'(max_x_q);
      best_y_o      <= ghv_pkg::PIX_W'(max_y_q);
      best_radius_o <= max_rad_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.clear_last = (clr_addr_q == AW'(DEPTH - 1));
    stat_o.r_done     = (r_q >= R_W'(re_q));
    stat_o.r_skip     = (mag < R_W'(ghv_pkg::SKIP_MAG));
    stat_o.div_last   = (idx_q == '0);
    stat_o.centre_ok  = (vx > V_LO) && (vx < V_HI_X) && (vy > V_LO) && (vy < V_HI_Y);
    stat_o.out_busy   = out_valid_q & ~out_ready_i;
  end

endmodule

// ===== rtl/core/gradient_circle_hough_vote_top.sv =====
// gradient_circle_hough_vote_top: gradient directed circle hough voter, top level
//
//   channel   dir  handshake      word
//   pix_i     in   valid/ready    pixel_x, pixel_y, cos_dir, sin_dir
//   res_o     out  valid/ready    best_votes, best_x, best_y, best_radius
//   cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_data_i
//
// one pixel at a time: per radius step, a radius under the skip limit only advances; any
// other runs the bin divider and the centre arithmetic, and a centre on the image then
// reads its vote counter and writes it back; the one bit a cycle bin divider gives
// QW = clog2(MAX_RADIUS_BINS) quotient bits, and the store read is registered
// the default range has 64 steps, 24 of them past the skip limit, and 16 bins
// after reset the vote store, MAX_RADIUS_BINS*IMAGE_HEIGHT*IMAGE_WIDTH counters (262144
// by default), is swept to zero, one counter a cycle, with pix_i held off
// the next pixel is taken while a result word still waits on res_o; a pixel then
// finishes its steps and holds until that word has gone
module gradient_circle_hough_vote_top #(
  parameter int IMAGE_WIDTH     = ghv_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT    = ghv_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_RADIUS_BINS = ghv_pkg::MAX_RADIUS_BINS_DEF,
  parameter int COUNT_WIDTH     = ghv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ghv_in_if.sink                         pix_i,
  ghv_out_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [ghv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ghv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  ghv_pkg::ghv_cmd_t  cmd;
  ghv_pkg::ghv_stat_t stat;
  logic               in_ready;

  ghv_ctrl u_ghv_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // ready only in the idle state, so the pixel word is captured on start
  assign pix_i.ready = in_ready;

  ghv_dpath #(
    .IMAGE_WIDTH     (IMAGE_WIDTH),
    .IMAGE_HEIGHT    (IMAGE_HEIGHT),
    .MAX_RADIUS_BINS (MAX_RADIUS_BINS),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_ghv_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_x_i     (pix_i.pixel_x),
    .pixel_y_i     (pix_i.pixel_y),
    .cos_dir_i     (pix_i.cos_dir),
    .sin_dir_i     (pix_i.sin_dir),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .best_votes_o  (res_o.best_votes),
    .best_x_o      (res_o.best_x),
    .best_y_o      (res_o.best_y),
    .best_radius_o (res_o.best_radius)
  );

endmodule

// ===== rtl/core/ghv_checker.sv =====
// ghv_checker: port level checks of the circle hough voter, bound to the top level
module ghv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ghv_pkg::VOTES_W-1:0]   best_votes_i,
  input logic [ghv_pkg::PIX_W-1:0]     best_x_i,
  input logic [ghv_pkg::PIX_W-1:0]     best_y_i,
  input logic [ghv_pkg::BRAD_W-1:0]    best_radius_i
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  // pixels taken whose result word has not gone yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result word with no pixel outstanding");

  a_in_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pending_q <= 2'd1)
    else $error("pixel taken with two results outstanding");

  a_one_word_each: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !in_acc && pending_q == 2'd1) |=> !out_valid_i)
    else $error("second result word for one pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(best_votes_i)
      && $stable(best_x_i) && $stable(best_y_i) && $stable(best_radius_i))
    else $error("stalled result word changed");

endmodule

bind gradient_circle_hough_vote_top ghv_checker u_ghv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .best_votes_i  (res_o.best_votes),
  .best_x_i      (res_o.best_x),
  .best_y_i      (res_o.best_y),
  .best_radius_i (res_o.best_radius)
);

// ===== sim/ghv_vote_checker.sv =====
`timescale 1ns / 1ps
// ghv_vote_checker: watches pixel and best vote words, predicts the vote store and compares
module ghv_vote_checker #(
  parameter int IMAGE_WIDTH     = ghv_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT    = ghv_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_RADIUS_BINS = ghv_pkg::MAX_RADIUS_BINS_DEF,
  parameter int COUNT_WIDTH     = ghv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ghv_in_if                              pix_i,
  ghv_out_if                             res_i,
  input  logic                           cfg_we_i,
  input  logic [ghv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ghv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             mismatch_o,
  output int                             pending_o,
  output int                             checked_o
);
  import ghv_pkg::*;

  localparam int STORE_DEPTH = MAX_RADIUS_BINS * IMAGE_HEIGHT * IMAGE_WIDTH;

  typedef struct packed {
    logic [VOTES_W-1:0] votes;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [BRAD_W-1:0]  radius;
  } best_word_t;

  bit [COUNT_WIDTH-1:0]    vote_store [STORE_DEPTH];
  best_word_t              best_seen;
  best_word_t              best_words_q [$];
  logic signed [RAD_W-1:0] rad_first;
  logic signed [RAD_W-1:0] rad_limit;
  logic [STEP_W-1:0]       rad_step;
  logic [BINS_CFG_W-1:0]   rad_bins;

  task automatic report_mismatch(string msg);
    mismatch_o++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // walks the radius range for one edge pixel and updates store and best vote
  task automatic cast_votes(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                            input logic signed [DIR_W-1:0] c,
                            input logic signed [DIR_W-1:0] s);
    longint step, nbins, first, lim, span, r, mag, bin, x0, y0, idx, cl, sl;
    bit [COUNT_WIDTH-1:0] cnt;
    step  = (rad_step == '0) ? 1 : longint'(rad_step);
    nbins = (rad_bins == '0) ? 1 : longint'(rad_bins);
    if (nbins > MAX_RADIUS_BINS) nbins = MAX_RADIUS_BINS;
    first = rad_first;
    lim   = rad_limit;
    span  = lim - first;
    cl    = c;
    sl    = s;
    for (r = first; r < lim; r += step) begin
      mag = (r < 0) ? -r : r;
      if (mag < SKIP_MAG) continue;
      bin = ((r - first) * nbins) / span;
      if (bin > nbins - 1) bin = nbins - 1;
      // division of a signed longint truncates toward zero
      x0 = (longint'(px) * (64'sd1 << FRAC_SHIFT) - r * cl + (64'sd1 << (FRAC_SHIFT - 1)))
           / (64'sd1 << FRAC_SHIFT);
      y0 = (longint'(py) * (64'sd1 << FRAC_SHIFT) - r * sl + (64'sd1 << (FRAC_SHIFT - 1)))
           / (64'sd1 << FRAC_SHIFT);
      if (x0 < 0 || x0 >= IMAGE_WIDTH || y0 < 0 || y0 >= IMAGE_HEIGHT) continue;
      idx = x0 + y0 * IMAGE_WIDTH + bin * IMAGE_HEIGHT * IMAGE_WIDTH;
      cnt = vote_store[idx];
      if (cnt != '1) cnt = cnt + 1'b1;
      vote_store[idx] = cnt;
      if (cnt > best_seen.votes) begin
        best_seen.votes  = VOTES_W'(cnt);
        best_seen.x      = PIX_W'(x0);
        best_seen.y      = PIX_W'(y0);
        best_seen.radius = BRAD_W'((mag + ROUND_ADD) >> PIX_SUBBITS);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    best_word_t want;
    if (!rst_ni) begin
      foreach (vote_store[i]) vote_store[i] = '0;
      best_seen = '0;
      best_words_q.delete();
      rad_first  = RADIUS_START_RST;
      rad_limit  = RADIUS_END_RST;
      rad_step   = RADIUS_STEP_RST;
      rad_bins   = RADIUS_BINS_RST;
      mismatch_o = 0;
      checked_o  = 0;
      pending_o <= 0;
    end else begin
      if (pix_i.valid && pix_i.ready) begin
        cast_votes(pix_i.pixel_x, pix_i.pixel_y, pix_i.cos_dir, pix_i.sin_dir);
        best_words_q.push_back(best_seen);
      end
      if (res_i.valid && res_i.ready) begin
        if (best_words_q.size() == 0) begin
          report_mismatch("best vote word with no pixel outstanding");
        end else begin
          want = best_words_q.pop_front();
          check_field("best_votes", int'(res_i.best_votes), int'(want.votes));
          check_field("best_x", int'(res_i.best_x), int'(want.x));
          check_field("best_y", int'(res_i.best_y), int'(want.y));
          check_field("best_radius", int'(res_i.best_radius), int'(want.radius));
          checked_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_RADIUS_START: rad_first = cfg_data_i[RAD_W-1:0];
          CFG_RADIUS_END:   rad_limit = cfg_data_i[RAD_W-1:0];
          CFG_RADIUS_STEP:  rad_step  = cfg_data_i[STEP_W-1:0];
          CFG_RADIUS_BINS:  rad_bins  = cfg_data_i[BINS_CFG_W-1:0];
          default: ;
        endcase
      end
      pending_o <= best_words_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus, radius settings and verdict for the gradient circle hough voter
module tb;
  import ghv_pkg::*;

  // random part size, on top of the directed pixels
  localparam int RANDOM_PIXELS = 350;
  // pixels in the counter full phase: 2816 votes each, so the counter tops out
  // during the 24th and stays there for the rest
  localparam int FULL_PIXELS   = 26;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int pixels_sent;
  int settings_used;
  bit gaps_on;

  ghv_in_if  pix_if ();
  ghv_out_if res_if ();

  gradient_circle_hough_vote_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ghv_vote_checker vote_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_i      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .mismatch_o (mismatches),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest correct run, including the store sweep after reset
  initial begin
    #(80_000_000);
    $display("gradient_circle_hough_vote_top test failed");
    $finish;
  end

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure, one process owns ready
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // holds the pixel side until every best vote word is back; the extra
  // cycles cover the block returning to idle after its last word
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // new radius setting, only ever written with the block idle
  task automatic set_radii(int first, int limit, int step, int bin_cnt);
    wait_drained();
    write_reg(CFG_RADIUS_START, CFG_DATA_W'(first));
    write_reg(CFG_RADIUS_END, CFG_DATA_W'(limit));
    write_reg(CFG_RADIUS_STEP, CFG_DATA_W'(step));
    write_reg(CFG_RADIUS_BINS, CFG_DATA_W'(bin_cnt));
    settings_used++;
    // roughly one setting in four runs without any idling
    gaps_on <= ($urandom_range(0, 3) != 0);
  endtask

  // valid stays high across back to back words, so it is only lowered for a gap
  task automatic send_pixel(int px, int py, int c, int s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= PIX_W'(px);
    pix_if.pixel_y <= PIX_W'(py);
    pix_if.cos_dir <= DIR_W'(c);
    pix_if.sin_dir <= DIR_W'(s);
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  function automatic int rand_dir();
    case ($urandom_range(0, 7))
      0:       return 16384;
      1:       return -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic int clamp_dir(int d);
    if (d > 16384) return 16384;
    if (d < -16384) return -16384;
    return d;
  endfunction

  // edge pixels lying on one circle with gradients pointing away from its centre,
  // so the votes pile up on a single centre and the tracked best keeps moving;
  // some stray pixels mixed in
  task automatic circle_phase();
    int  rad, cx, cy, lo, hi, n, k, px, py, dc, ds;
    bit  neg;
    real ang;
    rad = $urandom_range(40, 70);
    cx  = $urandom_range(0, 127);
    cy  = $urandom_range(0, 127);
    neg = $urandom_range(0, 1);
    lo  = rad * 16 - int'($urandom_range(0, 64));
    hi  = rad * 16 + int'($urandom_range(1, 64));
    // a negative radius with reversed gradients lands on the same centre
    if (neg) begin
      set_radii(-hi, -lo + 1, $urandom_range(1, 16), $urandom_range(1, 16));
    end else begin
      set_radii(lo, hi, $urandom_range(1, 16), $urandom_range(1, 16));
    end
    n = $urandom_range(10, 30);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_pixel($urandom_range(0, 127), $urandom_range(0, 127), rand_dir(), rand_dir());
      end else begin
        do begin
          ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
          px  = cx + int'(rad * $cos(ang));
          py  = cy + int'(rad * $sin(ang));
        end while (px < 0 || px > 127 || py < 0 || py > 127);
        dc = clamp_dir(int'(16384.0 * $cos(ang)) + int'($urandom_range(0, 64)) - 32);
        ds = clamp_dir(int'(16384.0 * $sin(ang)) + int'($urandom_range(0, 64)) - 32);
        if (neg) begin
          dc = -dc;
          ds = -ds;
        end
        send_pixel(px, py, dc, ds);
      end
    end
  endtask

  // any radius setting at all, kept to at most 64 steps a pixel
  task automatic noise_phase();
    int first, limit, step, n, k;
    first = int'($urandom_range(0, 4095)) - 2048;
    step  = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 255));
    limit = first + int'($urandom_range(1, (step == 0 ? 1 : step) * 64));
    if (limit > 2047) limit = 2047;
    // sometimes an empty or reversed range
    if ($urandom_range(0, 7) == 0) limit = int'($urandom_range(0, first + 2048)) - 2048;
    set_radii(first, limit, step, $urandom_range(0, 31));
    n = $urandom_range(10, 30);
    for (k = 0; k < n; k++) begin
      send_pixel($urandom_range(0, 127), $urandom_range(0, 127), rand_dir(), rand_dir());
    end
  endtask

  initial begin
    int target;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_RADIUS_START;
    cfg_data       = '0;
    pix_if.valid   = 1'b0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;
    pix_if.cos_dir = '0;
    pix_if.sin_dir = '0;
    gaps_on        = 1'b1;
    pixels_sent    = 0;
    settings_used  = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset radii (0 up to 64 px, 1 px steps, 16 bins); no register write
    // until the store sweep is over and the first words are back
    send_pixel(64, 64, 16384, 0);
    send_pixel(64, 64, -16384, 0);
    send_pixel(0, 0, 0, 0);          // zero gradient: every step past the skip limit votes on the pixel itself
    send_pixel(127, 127, 16384, 16384);
    send_pixel(127, 0, -16384, -16384);
    send_pixel(0, 0, 0, 0);          // same centres again, counts go to eight

    // one step at exactly 40 px: centres just left of column zero
    set_radii(640, 656, 16, 1);
    send_pixel(0, 5, 328, 0);        // -0.3 truncates to zero, inside
    send_pixel(0, 5, 1000, 0);       // -1.9 truncates to -1, off the image
    send_pixel(0, 0, 600, 600);      // both coordinates in (-1, 0)

    // single radius of -40.5 px, zero step taken as one, zero bins taken as one;
    // nine hits lift the best past the eight of the zero gradient pixels so the
    // half-up rounding shows
    set_radii(-648, -647, 0, 0);
    repeat (9) send_pixel(50, 50, 16384, 0);

    // +40.5 px with more bins than the store holds
    set_radii(648, 649, 0, 31);
    repeat (4) send_pixel(20, 20, 0, 16384);

    // empty ranges: the best word just repeats
    set_radii(100, 100, 16, 16);
    send_pixel(10, 10, 16384, 16384);
    set_radii(2047, -2048, 255, 17);
    send_pixel(117, 117, -16384, -16384);

    // full signed span with the largest step
    set_radii(-2048, 2047, 255, 16);
    send_pixel(127, 0, 16384, -16384);
    send_pixel(0, 127, -16384, 16384);

    // random part, mostly circles with some pure noise settings
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      if ($urandom_range(0, 2) != 0) circle_phase();
      else noise_phase();
    end

    // counter full: one bin, every radius, zero gradient so all 2816 voting
    // steps hit the same counter; goes last as the best then stays pinned
    set_radii(-2048, 2047, 1, 1);
    repeat (FULL_PIXELS) send_pixel(33, 77, 0, 0);

    wait_drained();
    // then a wait for any stray word to show up
    repeat (300) @(posedge clk_i);

    $display("%0d edge pixels under %0d radius settings, %0d best vote words compared",
             pixels_sent, settings_used, checked);
    $display("included circles, noise, empty and reversed ranges, odd bin counts and a full counter");
    if (mismatches == 0) begin
      $display("gradient_circle_hough_vote_top test passed");
    end else begin
      $display("gradient_circle_hough_vote_top test failed");
    end
    $finish;
  end

endmodule
